### src/ice_pkg.sv
`default_nettype none
package ice_pkg;
	localparam int WordBitsDef = 32;
	localparam int DispBits = 32;

	typedef enum logic [1:0] {
		CMD_DIGIT = 2'd0,
		CMD_OPER  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_MOD = 4'd4, OP_OR = 4'd5, OP_AND = 4'd6, OP_SHR = 4'd7,
		OP_SHL = 4'd8, OP_XOR = 4'd9, OP_EQU = 4'd10, OP_NEG = 4'd11,
		OP_NOT = 4'd12
	} op_t;

	localparam logic [3:0] CLR_DIGIT = 4'd0;
	localparam logic [3:0] CLR_ENTRY = 4'd1;
	localparam logic [3:0] CLR_ALL   = 4'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVF   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_UNS  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE, S_DIGIT, S_MUL, S_DIV, S_SHIFT, S_FIX, S_DONE
	} state_t;
endpackage
`default_nettype wire

### src/ice_serial_unit.sv
`default_nettype none
// Bit-serial multiply / divide: one bit per cycle over a shift register.
module ice_serial_unit import ice_pkg::*; #(
	parameter int WordBits = WordBitsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                is_div,
	input  wire logic [WordBits-1:0] opa,
	input  wire logic [WordBits-1:0] opb,
	output logic                     busy,
	output logic [WordBits-1:0]      quo_prod,
	output logic [WordBits-1:0]      rem
);
	localparam int CntBits = $clog2(WordBits + 1);
	logic [CntBits-1:0]  cnt_q;
	logic                div_q;
	logic [WordBits-1:0] a_q, b_q, r_q;
	logic [WordBits:0]   trial;

	assign trial = {r_q, a_q[WordBits-1]} - {1'b0, b_q};
	assign busy = (cnt_q != '0);
	assign quo_prod = div_q ? a_q : r_q;
	assign rem = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			div_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CntBits'(WordBits);
			div_q <= is_div;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= opa;
			b_q <= opb;
			r_q <= '0;
		end else if (busy) begin
			if (div_q) begin
				if (!trial[WordBits]) begin
					r_q <= trial[WordBits-1:0];
					a_q <= {a_q[WordBits-2:0], 1'b1};
				end else begin
					r_q <= {r_q[WordBits-2:0], a_q[WordBits-1]};
					a_q <= {a_q[WordBits-2:0], 1'b0};
				end
			end else begin
				// shift-add from the multiplier's top bit down
				r_q <= {r_q[WordBits-2:0], 1'b0} + (a_q[WordBits-1] ? b_q : '0);
				a_q <= {a_q[WordBits-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### src/integer_calculator_engine.sv
`default_nettype none
// Channel | Dir | Payload
// s_axis  | in  | tuser[1:0] command; tdata[3:0] key_code
// m_axis  | out | tdata[31:0] display_word, tdata[33:32] key_status; tuser shows_accumulator
// cfg     | in  | cfg_we, cfg_index (0 base, 1 unsigned_mode), cfg_data
//
// One key at a time. Simple keys go through S_FIX and S_DONE before the
// result is raised. Multiply, divide, modulo and clear-digit run the bit-serial
// unit once (divide and modulo only with a nonzero divisor). Digit entry runs
// it twice (multiply, then check divide). A shift by n (1 to WORD_BITS-1)
// moves one bit per cycle in S_SHIFT. The next key is accepted only once the
// result has been transferred. Reset clears all state but the serial unit's
// data registers; a stalled result holds in the output register and delays the next key.
module integer_calculator_engine import ice_pkg::*; #(
	parameter int WORD_BITS = WordBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // key_code
	input  wire logic [1:0]  s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // display_word, key_status
	output logic             m_axis_tuser,  // shows_accumulator
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);
	localparam int W = WORD_BITS;
	localparam int SB = $clog2(W + 1);

	state_t state_q, state_d;
	logic [4:0] base_q;
	logic       uns_q;
	logic [W-1:0] entry_q, acc_q;
	logic [3:0]   pend_q;
	logic         fresh_q, lsa_q;
	logic [1:0]   cmd_q;
	logic [3:0]   key_q;
	logic         phase_q;    // digit: 0 multiply, 1 check
	logic [W-1:0] tmp_q;      // candidate entry / shift work word
	logic [SB-1:0] shcnt_q;
	logic         neg_q;
	logic [DispBits-1:0] odisp_q;
	logic         oacc_q, ovalid_q;
	logic [1:0]   ost_q;

	logic [4:0] base_e;
	logic [W-1:0] base_w;
	logic sgn, na, nb;
	logic [W-1:0] ma, mb;
	logic su_start, su_div, su_busy;
	logic [W-1:0] su_a, su_b, su_q, su_r;

	always_comb begin
		if (base_q < 5'd2) base_e = 5'd2;
		else if (base_q > 5'd16) base_e = 5'd16;
		else base_e = base_q;
	end
	assign base_w = W'(base_e);
	assign sgn = ~uns_q;
	assign na = sgn & acc_q[W-1];
	assign nb = sgn & entry_q[W-1];
	assign ma = na ? -acc_q : acc_q;
	assign mb = nb ? -entry_q : entry_q;

	ice_serial_unit #(.WordBits(W)) u_ser (
		.clk, .arst_n, .start(su_start), .is_div(su_div), .opa(su_a), .opb(su_b),
		.busy(su_busy), .quo_prod(su_q), .rem(su_r)
	);

	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {6'd0, ost_q, odisp_q};
	assign m_axis_tuser = oacc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 5'd10;
			uns_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE) base_q <= cfg_data;
			else uns_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		su_start = 1'b0;
		su_div = 1'b0;
		su_a = entry_q;
		su_b = base_w;
		unique case (state_q) inside
			S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_FIX;
			S_FIX: begin
				// dispatch the captured key
				state_d = S_DONE;
				if (cmd_q == CMD_DIGIT && W'(key_q) < base_w) begin
					su_start = 1'b1;
					su_a = fresh_q ? '0 : entry_q;
					state_d = S_DIGIT;
				end else if (cmd_q == CMD_OPER && key_q <= OP_EQU) begin
					case (pend_q) inside
						OP_MUL: begin
							su_start = 1'b1; su_a = acc_q; su_b = entry_q;
							state_d = S_MUL;
						end
						OP_DIV, OP_MOD: if (entry_q != '0) begin
							su_start = 1'b1; su_div = 1'b1; su_a = ma; su_b = mb;
							state_d = S_DIV;
						end
						OP_SHR, OP_SHL: if (entry_q < W'(W) && entry_q != '0)
							state_d = S_SHIFT;
						default: ;
					endcase
				end else if (cmd_q == CMD_CLEAR && key_q == CLR_DIGIT
						&& pend_q != OP_EQU) begin
					su_start = 1'b1; su_div = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIGIT: if (!su_busy) begin
				if (!phase_q) begin
					su_start = 1'b1; su_div = 1'b1;
					su_a = su_q + W'(key_q);
				end else state_d = S_DONE;
			end
			S_MUL, S_DIV: if (!su_busy) state_d = S_DONE;
			S_SHIFT: if (shcnt_q == SB'(1)) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0; acc_q <= '0; pend_q <= OP_ADD;
			fresh_q <= 1'b0; lsa_q <= 1'b0; ovalid_q <= 1'b0;
			phase_q <= 1'b0;
			cmd_q <= '0; key_q <= '0; tmp_q <= '0; shcnt_q <= '0; neg_q <= 1'b0;
			odisp_q <= '0; oacc_q <= 1'b0; ost_q <= ST_OK;
		end else begin
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					cmd_q <= s_axis_tuser;
					key_q <= s_axis_tdata[3:0];
					phase_q <= 1'b0;
				end
				S_FIX: begin
					tmp_q <= acc_q;
					shcnt_q <= SB'(entry_q);
					neg_q <= na;
					if (cmd_q == CMD_DIGIT && W'(key_q) < base_w && fresh_q) begin
						fresh_q <= 1'b0; acc_q <= '0; entry_q <= '0; pend_q <= OP_ADD;
					end
				end
				S_DIGIT: if (!su_busy && !phase_q) begin
					phase_q <= 1'b1;
					tmp_q <= su_q + W'(key_q);
				end
				S_SHIFT: begin
					shcnt_q <= shcnt_q - 1'b1;
					if (pend_q == OP_SHL) tmp_q <= {tmp_q[W-2:0], 1'b0};
					else tmp_q <= {neg_q, tmp_q[W-1:1]};
				end
				S_DONE: begin : fin
					logic [W-1:0] res, ne;
					logic sa;
					logic [1:0] st;
					res = acc_q;
					sa = lsa_q;
					st = ST_OK;
					ne = entry_q;
					ovalid_q <= 1'b1;
					case (cmd_q)
						CMD_DIGIT: if (W'(key_q) >= base_w) st = ST_RANGE;
						else begin
							if (su_q != entry_q) st = ST_OVF;
							else ne = tmp_q;
							sa = 1'b0;
							lsa_q <= 1'b0;
							entry_q <= ne;
						end
						CMD_OPER: if (key_q <= OP_NOT) begin
							fresh_q <= 1'b0;
							if (key_q == OP_NEG || key_q == OP_NOT) begin
								ne = (key_q == OP_NEG) ? -entry_q : ~entry_q;
								entry_q <= ne;
								if (pend_q == OP_EQU) acc_q <= ne;
								sa = 1'b0;
							end else begin
								case (pend_q)
									OP_ADD: res = acc_q + entry_q;
									OP_SUB: res = acc_q - entry_q;
									OP_MUL: res = su_q;
									OP_DIV: if (entry_q != '0)
										res = (na != nb) ? -su_q : su_q;
									OP_MOD: if (entry_q != '0)
										res = na ? -su_r : su_r;
									OP_OR:  res = acc_q | entry_q;
									OP_AND: res = acc_q & entry_q;
									OP_SHR: if (entry_q >= W'(W)) res = {W{na}};
										else res = tmp_q;
									OP_SHL: if (entry_q >= W'(W)) res = '0;
										else res = tmp_q;
									OP_XOR: res = acc_q ^ entry_q;
									default: res = acc_q;
								endcase
								acc_q <= res;
								pend_q <= key_q;
								if (key_q == OP_EQU) begin
									ne = res; fresh_q <= 1'b1; sa = 1'b0;
								end else begin
									ne = '0; sa = 1'b1;
								end
								entry_q <= ne;
							end
							lsa_q <= sa;
						end
						CMD_CLEAR: if (key_q <= CLR_ALL) begin
							// show the cleared values in the register last shown
							if (key_q == CLR_DIGIT) begin
								if (pend_q != OP_EQU) ne = su_q;
							end else if (key_q == CLR_ENTRY) ne = '0;
							else begin
								ne = '0; res = '0; acc_q <= '0; pend_q <= OP_ADD;
							end
							entry_q <= ne;
							lsa_q <= 1'b0;
						end
						default: ;
					endcase
					odisp_q <= DispBits'(sa ? res : ne);
					oacc_q <= sa;
					ost_q <= st;
				end
				default: ;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> ovalid_q) else $error("result not raised");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !m_axis_tready |=> ovalid_q && $stable(odisp_q))
		else $error("result dropped");
endmodule
`default_nettype wire

### tb/integer_calculator_engine_test.sv
`timescale 1ns / 100ps
`default_nettype none

module integer_calculator_engine_test import ice_pkg::*; ();

	// Expected display words, with the calculator state that produces them
	class display_board;
		logic [31:0] entry_val, accum;
		logic [3:0]  pend_op;
		logic        fresh, last_acc;
		logic [4:0]  base_reg;
		logic        uns;
		logic [34:0] want_q[$];
		int          errors;

		function void clear_state();
			entry_val = '0;
			accum = '0;
			pend_op = OP_ADD;
			fresh = 1'b0;
			last_acc = 1'b0;
			base_reg = 5'd10;
			uns = 1'b1;
			errors = 0;
			want_q = {};
		endfunction

		function logic [31:0] neg32(logic [31:0] x);
			return 32'd0 - x;
		endfunction

		function logic [31:0] apply_pending(logic [3:0] op, logic [31:0] a, logic [31:0] b);
			logic        na, nb;
			logic [31:0] ma, mb, r;
			na = !uns && a[31];
			nb = !uns && b[31];
			ma = na ? neg32(a) : a;
			mb = nb ? neg32(b) : b;
			case (op)
				OP_ADD: return a + b;
				OP_SUB: return a - b;
				OP_MUL: return a * b;
				OP_DIV: begin
					if (b == 0) return a;
					r = ma / mb;
					return (na != nb) ? neg32(r) : r;
				end
				OP_MOD: begin
					if (b == 0) return a;
					r = ma % mb;
					return na ? neg32(r) : r;
				end
				OP_OR:  return a | b;
				OP_AND: return a & b;
				OP_SHR: begin
					if (b >= 32) return na ? '1 : '0;
					r = a >> b;
					if (na) r = r | ~({32{1'b1}} >> b);
					return r;
				end
				OP_SHL: return (b >= 32) ? '0 : (a << b);
				OP_XOR: return a ^ b;
				default: return a;
			endcase
		endfunction

		// Note one accepted key and queue the display it should produce
		function void note_key(logic [1:0] cmd, logic [3:0] key);
			logic [31:0] eb;
			logic [63:0] t;
			logic [1:0]  status;
			logic        show;
			eb = (base_reg < 2) ? 2 : (base_reg > 16) ? 16 : base_reg;
			status = ST_OK;
			show = last_acc;
			if (cmd == CMD_DIGIT) begin
				if (key >= eb) status = ST_RANGE;
				else begin
					if (fresh) begin
						fresh = 1'b0;
						accum = '0;
						entry_val = '0;
						pend_op = OP_ADD;
					end
					t = {32'd0, (entry_val * eb + key)};
					if (t[31:0] / eb != entry_val) status = ST_OVF;
					else entry_val = t[31:0];
					show = 1'b0;
					last_acc = 1'b0;
				end
			end else if (cmd == CMD_OPER && key <= OP_NOT) begin
				fresh = 1'b0;
				if (key == OP_NEG || key == OP_NOT) begin
					entry_val = (key == OP_NEG) ? neg32(entry_val) : ~entry_val;
					if (pend_op == OP_EQU) accum = entry_val;
					show = 1'b0;
				end else begin
					accum = apply_pending(pend_op, accum, entry_val);
					pend_op = key;
					if (key == OP_EQU) begin
						entry_val = accum;
						fresh = 1'b1;
						show = 1'b0;
					end else begin
						entry_val = '0;
						show = 1'b1;
					end
				end
				last_acc = show;
			end else if (cmd == CMD_CLEAR && key <= CLR_ALL) begin
				if (key == CLR_DIGIT) begin
					if (pend_op != OP_EQU) entry_val = entry_val / eb;
				end else if (key == CLR_ENTRY) entry_val = '0;
				else begin
					accum = '0;
					entry_val = '0;
					pend_op = OP_ADD;
				end
				last_acc = 1'b0;
			end
			want_q.push_back({status, show, show ? accum : entry_val});
		endfunction

		function void check_display(logic [39:0] data, logic flag);
			logic [34:0] w;
			logic [34:0] got;
			got = {data[33:32], flag, data[31:0]};
			if (want_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected display transfer %h", got);
				return;
			end
			w = want_q.pop_front();
			if (got !== w) begin
				errors++;
				if (errors <= 10)
					$display("display mismatch: word exp %h got %h, acc exp %b got %b, status exp %0d got %0d",
						w[31:0], got[31:0], w[32], got[32], w[34:33], got[34:33]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;

	display_board board;
	bit          stall_on;

	integer_calculator_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// Check every display transfer as it happens
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_display(m_axis_tdata, m_axis_tuser);

	// Receiver stall pattern: mostly ready, with random back-pressure when enabled
	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else if (!stall_on) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 9) < 6);
	end

	// Drive one key, holding it until the transfer completes
	task automatic send_key(logic [1:0] cmd, logic [3:0] key);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, key};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		board.note_key(cmd, key);
	endtask

	task automatic drop_valid();
		s_axis_tvalid <= 1'b0;
	endtask

	// Wait until all displays have come back, then let the engine settle
	task automatic drain();
		drop_valid();
		@(posedge clk);
		while (board.want_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BASE) board.base_reg = val;
		else board.uns = val[0];
	endtask

	// Well-formed keys mostly; a little noise with unknown codes
	task automatic random_key();
		int sel;
		logic [3:0] k;
		sel = $urandom_range(0, 99);
		k = 4'($urandom);
		if (sel < 50) send_key(CMD_DIGIT, (sel < 45) ? 4'($urandom_range(0, 15)) : k);
		else if (sel < 85) send_key(CMD_OPER, 4'($urandom_range(0, 12)));
		else if (sel < 95) send_key(CMD_CLEAR, 4'($urandom_range(0, 2)));
		else send_key(2'($urandom), k);
	endtask

	// Bursts of keys, most followed by a random gap
	task automatic run_phase(int count);
		int n;
		n = 0;
		while (n < count) begin
			int burst;
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				random_key();
				n++;
			end
			if ($urandom_range(0, 2) != 0) begin
				drop_valid();
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic [4:0] bases[6];
		bases = '{5'd2, 5'd8, 5'd10, 5'd16, 5'd0, 5'd31};
		board = new();
		board.clear_state();
		stall_on = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: digits, overflow, every operator, clears, unknown codes
		send_key(CMD_DIGIT, 4'd9);
		send_key(CMD_DIGIT, 4'd15);
		send_key(CMD_OPER, OP_NEG);
		send_key(CMD_OPER, OP_DIV);
		send_key(CMD_OPER, OP_EQU);
		for (int op = 0; op <= 12; op++) begin
			send_key(CMD_DIGIT, 4'd7);
			send_key(CMD_OPER, 4'(op));
		end
		send_key(CMD_OPER, OP_EQU);
		send_key(CMD_CLEAR, CLR_DIGIT);
		send_key(CMD_DIGIT, 4'd4);
		repeat (11) send_key(CMD_DIGIT, 4'd9);
		send_key(CMD_CLEAR, CLR_DIGIT);
		send_key(CMD_CLEAR, CLR_ENTRY);
		send_key(CMD_CLEAR, CLR_ALL);
		send_key(CMD_OPER, 4'd15);
		send_key(CMD_CLEAR, 4'd15);
		send_key(2'd3, 4'd15);
		drain();

		// Signed extremes: most negative by -1, big shifts
		write_reg(REG_UNS, 5'd0);
		write_reg(REG_BASE, 5'd16);
		send_key(CMD_DIGIT, 4'd8);
		repeat (7) send_key(CMD_DIGIT, 4'd0);
		send_key(CMD_OPER, OP_DIV);
		send_key(CMD_DIGIT, 4'd1);
		send_key(CMD_OPER, OP_NEG);
		send_key(CMD_OPER, OP_MOD);
		send_key(CMD_DIGIT, 4'd15);
		send_key(CMD_OPER, OP_NOT);
		send_key(CMD_OPER, OP_SHR);
		send_key(CMD_DIGIT, 4'd15);
		send_key(CMD_DIGIT, 4'd15);
		send_key(CMD_OPER, OP_EQU);
		drain();

		// Random phases across bases and sign modes
		for (int ph = 0; ph < 12; ph++) begin
			stall_on = (ph % 3) != 0;
			write_reg(REG_BASE, bases[ph % 6]);
			write_reg(REG_UNS, 5'($urandom_range(0, 1)));
			run_phase(170);
			drain();
		end

		stall_on = 1'b0;
		drain();
		if (board.errors == 0 && board.want_q.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire

### sim.f
src/ice_pkg.sv
src/ice_serial_unit.sv
src/integer_calculator_engine.sv
tb/integer_calculator_engine_test.sv
